>>> src/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
// No dependencies; mf3_if, the core and mf3_sort refer to this package.
package mf3_pkg;

    localparam int PIXEL_W      = 8;
    localparam int COORD_W      = 10;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 8;
    localparam int NB_PIXELS    = 9;
    localparam int MIN_DIM      = 3;
    localparam int RESET_DIM    = 256;
    localparam int HEIGHT_LIMIT = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CFG_W-1:0]   t_dim;

    typedef t_pixel [NB_PIXELS-1:0] t_nbhd;

    typedef struct packed {
        t_coord col;
        t_coord row;
        logic   last;
    } t_tag;

endpackage

>>> src/mf3_if.sv
// Stream and configuration interfaces of the 3x3 median filter.
// Depends on mf3_pkg for payload types.
interface mf3_pixel_if;
    logic            valid;
    logic            ready;
    mf3_pkg::t_pixel pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mf3_result_if;
    logic            valid;
    logic            ready;
    mf3_pkg::t_pixel median_value;
    mf3_pkg::t_coord centre_column;
    mf3_pkg::t_coord centre_row;
    logic            frame_last;

    modport source (output valid, output median_value, output centre_column,
                    output centre_row, output frame_last, input ready);
    modport sink   (input valid, input median_value, input centre_column,
                    input centre_row, input frame_last, output ready);
endinterface

interface mf3_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mf3_pkg::CFG_IDX_W-1:0]       index;
    mf3_pkg::t_dim                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/median_filter_3x3_core.sv
// 3x3 median filter core: counters, line store access, window and median pipe.
// A result is registered in the first stage, the sort stages and the output register.
// Throughput: one pixel per cycle unless o_res stalls; one line store RMW per pixel.
// Reset: counters and window clear, sizes return to 256; line store holds no reset.
// Depends on mf3_pkg, mf3_if, mf3_line_mem and mf3_sort.
module median_filter_3x3_core #(
    parameter int MAX_LINE_PIXELS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mf3_pixel_if.sink     i_pix,
    mf3_cfg_if.sink       i_cfg,
    mf3_result_if.source  o_res
);

    localparam int AW = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
    localparam int WW = $clog2(MAX_LINE_PIXELS + 1);
    localparam int MW = 2 * mf3_pkg::PIXEL_W;

    function automatic logic [WW-1:0] clamp_w(mf3_pkg::t_dim v);
        logic [WW-1:0] res;
        if (32'(v) < mf3_pkg::MIN_DIM) begin
            res = WW'(mf3_pkg::MIN_DIM);
        end else if (32'(v) > MAX_LINE_PIXELS) begin
            res = WW'(MAX_LINE_PIXELS);
        end else begin
            res = WW'(v);
        end
        return res;
    endfunction

    function automatic mf3_pkg::t_dim clamp_h(mf3_pkg::t_dim v);
        mf3_pkg::t_dim res;
        if (32'(v) < mf3_pkg::MIN_DIM) begin
            res = mf3_pkg::t_dim'(mf3_pkg::MIN_DIM);
        end else if (32'(v) > mf3_pkg::HEIGHT_LIMIT) begin
            res = mf3_pkg::t_dim'(mf3_pkg::HEIGHT_LIMIT);
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [WW-1:0]      r_w;
    mf3_pkg::t_dim      r_h;
    logic [AW-1:0]      r_col, n_col;
    mf3_pkg::t_coord    r_row, n_row;
    logic               col_last, row_last, acc, cfg_hit;

    logic               r_v1, r_prod1;
    logic [AW-1:0]      r_addr1;
    mf3_pkg::t_pixel    r_pix1;
    mf3_pkg::t_tag      r_tag1;
    mf3_pkg::t_pixel    r_win [3][2];
    logic [MW-1:0]      rd_data;
    mf3_pkg::t_pixel    top, mid;
    mf3_pkg::t_nbhd     nbhd;
    logic               leave1, sort_ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_hit = i_cfg.valid && (i_cfg.index == mf3_pkg::REG_FRAME_WIDTH ||
                                     i_cfg.index == mf3_pkg::REG_FRAME_HEIGHT);

    assign leave1      = r_v1 && (!r_prod1 || sort_ready);
    assign i_pix.ready = !r_v1 || leave1;
    assign acc         = i_pix.valid && i_pix.ready;

    assign col_last = (WW'(r_col) + WW'(1)) == r_w;
    assign row_last = (mf3_pkg::t_dim'(r_row) + mf3_pkg::t_dim'(1)) == r_h;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + mf3_pkg::t_coord'(1);
        end else begin
            n_col = r_col + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= clamp_w(mf3_pkg::t_dim'(mf3_pkg::RESET_DIM));
            r_h   <= clamp_h(mf3_pkg::t_dim'(mf3_pkg::RESET_DIM));
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            if (i_cfg.index == mf3_pkg::REG_FRAME_WIDTH) begin
                r_w <= clamp_w(i_cfg.data);
            end else begin
                r_h <= clamp_h(i_cfg.data);
            end
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (acc) begin
            r_v1 <= 1'b1;
        end else if (leave1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_addr1     <= r_col;
            r_pix1      <= i_pix.pixel_value;
            r_prod1     <= (r_row >= mf3_pkg::t_coord'(2)) && (r_col >= AW'(2));
            r_tag1.col  <= mf3_pkg::t_coord'(r_col) - mf3_pkg::t_coord'(1);
            r_tag1.row  <= r_row - mf3_pkg::t_coord'(1);
            r_tag1.last <= row_last && col_last;
        end
    end

    mf3_line_mem #(
        .DEPTH (MAX_LINE_PIXELS),
        .AW    (AW),
        .DW    (MW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (leave1),
        .i_wr_addr (r_addr1),
        .i_wr_data ({mid, r_pix1})
    );

    assign top = rd_data[MW-1 -: mf3_pkg::PIXEL_W];
    assign mid = rd_data[mf3_pkg::PIXEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= '0;
                r_win[k][1] <= '0;
            end
        end else if (leave1) begin
            r_win[0][0] <= r_win[0][1];
            r_win[0][1] <= top;
            r_win[1][0] <= r_win[1][1];
            r_win[1][1] <= mid;
            r_win[2][0] <= r_win[2][1];
            r_win[2][1] <= r_pix1;
        end
    end

    assign nbhd = {r_pix1, r_win[2][1], r_win[2][0],
                   mid,    r_win[1][1], r_win[1][0],
                   top,    r_win[0][1], r_win[0][0]};

    mf3_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1 && r_prod1),
        .o_ready (sort_ready),
        .i_nbhd  (nbhd),
        .i_tag   (r_tag1),
        .o_res   (o_res)
    );

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < r_w)
        else $error("column counter beyond row width");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && leave1) |-> (r_col != r_addr1))
        else $error("line store read and write hit the same entry");

    a_stage_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v1)
        else $error("transferred pixel missing from first stage");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !leave1) |=> (r_v1 && $stable(r_addr1) && $stable(r_pix1)))
        else $error("stalled first stage changed");

endmodule

>>> src/mf3_line_mem.sv
// Line store memory: one entry per column holding the two rows above.
// Synchronous read into a registered output, one write port. Uses no package.
module mf3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/mf3_sort.sv
// Pipelined nine-input median network with output register.
// Depends on mf3_pkg and mf3_result_if.
module mf3_sort (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mf3_pkg::t_nbhd       i_nbhd,
    input  mf3_pkg::t_tag        i_tag,
    mf3_result_if.source         o_res
);

    function automatic mf3_pkg::t_pixel min2(mf3_pkg::t_pixel a, mf3_pkg::t_pixel b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::t_pixel max2(mf3_pkg::t_pixel a, mf3_pkg::t_pixel b);
        return (a > b) ? a : b;
    endfunction

    function automatic mf3_pkg::t_pixel med3(mf3_pkg::t_pixel a, mf3_pkg::t_pixel b,
                                             mf3_pkg::t_pixel c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic               r_v2, r_v3, r_vo;
    mf3_pkg::t_pixel    r_lo [3];
    mf3_pkg::t_pixel    r_md [3];
    mf3_pkg::t_pixel    r_hi [3];
    mf3_pkg::t_tag      r_tag2, r_tag3, r_tago;
    mf3_pkg::t_pixel    r_a, r_b, r_c, r_med;
    logic               ld_2, ld_3, ld_o;

    assign ld_o    = r_v3 && (!r_vo || o_res.ready);
    assign ld_3    = r_v2 && (!r_v3 || ld_o);
    assign o_ready = !r_v2 || ld_3;
    assign ld_2    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ld_2) begin
                r_v2 <= 1'b1;
            end else if (ld_3) begin
                r_v2 <= 1'b0;
            end
            if (ld_3) begin
                r_v3 <= 1'b1;
            end else if (ld_o) begin
                r_v3 <= 1'b0;
            end
            if (ld_o) begin
                r_vo <= 1'b1;
            end else if (o_res.ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_2) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= min2(min2(i_nbhd[3*k], i_nbhd[3*k+1]), i_nbhd[3*k+2]);
                r_md[k] <= med3(i_nbhd[3*k], i_nbhd[3*k+1], i_nbhd[3*k+2]);
                r_hi[k] <= max2(max2(i_nbhd[3*k], i_nbhd[3*k+1]), i_nbhd[3*k+2]);
            end
            r_tag2 <= i_tag;
        end
        if (ld_3) begin
            r_a    <= max2(max2(r_lo[0], r_lo[1]), r_lo[2]);
            r_b    <= med3(r_md[0], r_md[1], r_md[2]);
            r_c    <= min2(min2(r_hi[0], r_hi[1]), r_hi[2]);
            r_tag3 <= r_tag2;
        end
        if (ld_o) begin
            r_med  <= med3(r_a, r_b, r_c);
            r_tago <= r_tag3;
        end
    end

    assign o_res.valid         = r_vo;
    assign o_res.median_value  = r_med;
    assign o_res.centre_column = r_tago.col;
    assign o_res.centre_row    = r_tago.row;
    assign o_res.frame_last    = r_tago.last;

endmodule
